@@ design/thd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the hysteresis thermostat display core.
// Depends on nothing; every other file of the block imports it.
package thd_pkg;

   // Operation codes of an input item
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_UP     = 2'd1;
   localparam logic [1:0] OP_DOWN   = 2'd2;

   // Display digit register addresses
   localparam logic [1:0] POS_HUNDREDS = 2'd1;
   localparam logic [1:0] POS_TENS     = 2'd2;
   localparam logic [1:0] POS_UNITS    = 2'd3;

   // Setpoint limits and reset values
   localparam logic signed [7:0] SP_MIN   = -8'sd55;
   localparam logic signed [7:0] SP_MAX   = 8'sd125;
   localparam logic signed [7:0] SP_RESET = 8'sd25;
   localparam logic [3:0]        HYST_RESET = 4'd1;

   // Input item
   typedef struct packed {
      logic [1:0]        op;
      logic signed [7:0] temperature;
   } req_type;

   // Result item
   typedef struct packed {
      logic [1:0] digit_position;
      logic [3:0] digit_value;
      logic       relay_drive;
      logic       last_of_run;
   } rsp_type;

   // Item as it waits between front and back: value to show and relay level
   typedef struct packed {
      logic [6:0] shown;
      logic       relay;
   } entry_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ design/hysteresis_thermostat_display_core.sv @@
`timescale 1ns / 1ps
// On-off thermostat with hysteresis and three-digit display writes.
// Top level; depends on thd_pkg, thd_front, thd_queue and thd_back.
//
// Input channel (req_): push an item while full is low. An item is a
// temperature sample or a setpoint up or down press. The front updates
// setpoint, last temperature and relay level in the accepting cycle.
// Result channel (rsp_): each item yields three digit writes, hundreds,
// tens and units, with the relay level; the third carries last_of_run.
// A result is on rsp_data while rsp_empty is low and leaves on rsp_pop.
// An accepted item goes into the queue, then, when the back is free, into
// the back's digit registers, where its first digit write shows. The back
// hands out one digit per pop and loads the next item on the last pop.
// The queue of QUEUE_DEPTH items lets the input run ahead while results
// stall; when it fills, req_full rises until the back frees an entry.
// Configuration (csr_): one write of the 4-bit hysteresis, always ready.
// Reset: setpoint 25, last temperature 0, relay low, hysteresis 1,
// queue and output empty.
module hysteresis_thermostat_display_core
   import thd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_wdata
);

   logic             accept;
   logic             qpop;
   entry_type        wr_entry, rd_entry;
   queue_status_type qstat;

   assign csr_ready = 1'b1;
   assign req_full  = qstat.full;
   assign accept    = req_push && !qstat.full;

   // Front: state update and classification
   thd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .hyst_wr   (csr_valid && csr_ready),
      .hyst_data (csr_wdata),
      .entry     (wr_entry)
   );

   // Queue between front and back
   thd_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (wr_entry),
      .rd_en   (qpop),
      .rd_data (rd_entry),
      .status  (qstat)
   );

   // Back: digit split and serial output
   thd_back u_back (
      .clock (clock),
      .reset (reset),
      .entry (rd_entry),
      .qstat (qstat),
      .qpop  (qpop),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rsp   (rsp_data)
   );

   // A shown digit write always addresses a real display position
   a_pos_valid: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.digit_position != 2'd0))
      else $error("digit write with position zero");

   // Within an item, positions advance one by one with no gap
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last_of_run) |=>
      (!rsp_empty && rsp_data.digit_position ==
       $past(rsp_data.digit_position) + 2'd1))
      else $error("digit sequence broken inside an item");

   // Relay level stays the same over the writes of one item
   a_relay_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last_of_run) |=>
      $stable(rsp_data.relay_drive))
      else $error("relay level changed inside an item");

endmodule

@@ design/thd_queue.sv @@
`timescale 1ns / 1ps
// Short item queue between the front and the back of the thermostat core.
// Depends on thd_pkg for the entry and status types.
module thd_queue
   import thd_pkg::*;
#(
   parameter int Depth = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  entry_type        wr_data,
   input  logic             rd_en,
   output entry_type        rd_data,
   output queue_status_type status
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   entry_type        entries_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_wr, do_rd;

   assign status.full  = (count_ff == CntW'(Depth));
   assign status.empty = (count_ff == '0);
   assign do_wr        = wr_en && !status.full;
   assign do_rd        = rd_en && !status.empty;
   assign rd_data      = entries_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ design/thd_front.sv @@
`timescale 1ns / 1ps
// Front of the thermostat core: accepts items, updates setpoint, temperature
// and relay, and queues the value to show. Depends on thd_pkg.
module thd_front
   import thd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req,
   input  logic      hyst_wr,
   input  logic [3:0] hyst_data,
   output entry_type entry
);

   logic signed [7:0] setpoint_ff, setpoint_in;
   logic signed [7:0] last_temp_ff, last_temp_in;
   logic              relay_ff, relay_in;
   logic [3:0]        hyst_ff;
   logic signed [9:0] temp_w, sp_w, low_w;
   logic signed [7:0] shown_full;

   // Setpoint step with saturation, temperature capture
   always_comb begin
      setpoint_in  = setpoint_ff;
      last_temp_in = last_temp_ff;
      if (req.op == OP_SAMPLE) begin
         last_temp_in = req.temperature;
      end else if (req.op == OP_UP && setpoint_ff < SP_MAX) begin
         setpoint_in = setpoint_ff + 8'sd1;
      end else if (req.op == OP_DOWN && setpoint_ff > SP_MIN) begin
         setpoint_in = setpoint_ff - 8'sd1;
      end
   end

   // Hysteresis comparison on the updated state
   always_comb begin
      temp_w   = {{2{last_temp_in[7]}}, last_temp_in};
      sp_w     = {{2{setpoint_in[7]}}, setpoint_in};
      low_w    = sp_w - $signed({6'b0, hyst_ff});
      relay_in = relay_ff;
      if (temp_w >= sp_w) begin
         relay_in = 1'b0;
      end else if (temp_w <= low_w) begin
         relay_in = 1'b1;
      end
   end

   // Shown value clamps negatives to zero
   always_comb begin
      shown_full  = (req.op == OP_SAMPLE) ? last_temp_in : setpoint_in;
      entry.shown = shown_full[7] ? 7'd0 : shown_full[6:0];
      entry.relay = relay_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= SP_RESET;
         last_temp_ff <= 8'sd0;
         relay_ff     <= 1'b0;
         hyst_ff      <= HYST_RESET;
      end else begin
         if (accept) begin
            setpoint_ff  <= setpoint_in;
            last_temp_ff <= last_temp_in;
            relay_ff     <= relay_in;
         end
         if (hyst_wr) begin
            hyst_ff <= hyst_data;
         end
      end
   end

endmodule

@@ design/thd_back.sv @@
`timescale 1ns / 1ps
// Back of the thermostat core: splits a queued value into decimal digits and
// hands out three digit writes, one per pop. Depends on thd_pkg.
module thd_back
   import thd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  entry_type        entry,
   input  queue_status_type qstat,
   output logic             qpop,
   input  logic             pop,
   output logic             empty,
   output rsp_type          rsp
);

   logic        busy_ff, busy_in;
   logic [1:0]  pos_ff, pos_in;
   logic [3:0]  hund_ff, tens_ff, units_ff;
   logic        relay_ff;
   logic        load, done;
   logic        hund_c;
   logic [6:0]  rem_c;
   logic [14:0] prod_c;
   logic [3:0]  tens_c;
   logic [6:0]  units_c;

   // Decimal split of 0..127: tens by multiply with 205/2048
   always_comb begin
      hund_c  = (entry.shown >= 7'd100);
      rem_c   = hund_c ? (entry.shown - 7'd100) : entry.shown;
      prod_c  = 15'(rem_c) * 15'd205;
      tens_c  = prod_c[14:11];
      units_c = rem_c - ({3'b0, tens_c} << 3) - ({3'b0, tens_c} << 1);
   end

   // Sequencing of the three digit writes
   assign done  = busy_ff && pop && (pos_ff == POS_UNITS);
   assign load  = (!busy_ff || done) && !qstat.empty;
   assign qpop  = load;
   assign empty = !busy_ff;

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (load) begin
         busy_in = 1'b1;
         pos_in  = POS_HUNDREDS;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff && pop) begin
         pos_in = pos_ff + 2'd1;
      end
   end

   // Result fields
   always_comb begin
      rsp.digit_position = pos_ff;
      rsp.relay_drive    = relay_ff;
      rsp.last_of_run    = (pos_ff == POS_UNITS);
      case (pos_ff)
         POS_HUNDREDS: rsp.digit_value = hund_ff;
         POS_TENS:     rsp.digit_value = tens_ff;
         default:      rsp.digit_value = units_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= POS_HUNDREDS;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
   end

   // Digit payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         hund_ff  <= {3'b0, hund_c};
         tens_ff  <= tens_c;
         units_ff <= units_c[3:0];
         relay_ff <= entry.relay;
      end
   end

endmodule

@@ tb/sv/tb_hysteresis_thermostat_display_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for hysteresis_thermostat_display_core.
// Depends on thd_pkg and the core; a directed table, then random runs, checked by a predictor.
module tb_hysteresis_thermostat_display_core;
   import thd_pkg::*;

   // Spare op code: setpoint unchanged, shown, relay compared again
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_CAP = 30;

   // One row of the directed stimulus; typed rows carry their own expected display
   typedef struct packed {
      logic [1:0]        op;
      logic signed [7:0] temp;
      logic              typed;
      logic [9:0]        shown;
      logic              relay;
   } directed_row_type;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   req_type    req_data;
   logic       rsp_empty;
   logic       rsp_pop;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [3:0] csr_wdata;

   // Predictor state
   logic signed [7:0] setpoint_now;
   logic signed [7:0] last_sample;
   logic              relay_on;
   logic [3:0]        hysteresis_cfg;
   rsp_type           pending_digit_writes [$];

   int  cycle_count = 0;
   int  mismatch_count = 0;
   int  items_sent = 0;
   int  writes_checked = 0;
   int  settings_used = 1;
   int  top_hits = 0;
   int  bottom_hits = 0;
   int  relay_flips = 0;
   bit  feed_calm = 0;
   bit  sink_calm = 0;

   // Directed rows, starting from reset: setpoint 25, hysteresis 1
   directed_row_type directed_rows [24] = '{
      '{OP_SAMPLE, 8'sd0,    1'b1, 10'd0,   1'b1},
      '{OP_SAMPLE, 8'sd125,  1'b1, 10'd125, 1'b0},
      '{OP_SAMPLE, -8'sd55,  1'b1, 10'd0,   1'b1},
      '{OP_SAMPLE, 8'sd25,   1'b1, 10'd25,  1'b0},
      '{OP_SAMPLE, 8'sd24,   1'b1, 10'd24,  1'b1},
      '{OP_SAMPLE, -8'sd128, 1'b1, 10'd0,   1'b1},
      '{OP_SAMPLE, 8'sd127,  1'b1, 10'd127, 1'b0},
      '{OP_SAMPLE, 8'sd126,  1'b0, 10'd0,   1'b0},
      '{OP_SAMPLE, -8'sd56,  1'b0, 10'd0,   1'b0},
      '{OP_UP,     8'sd0,    1'b1, 10'd26,  1'b1},
      '{OP_DOWN,   8'sd0,    1'b1, 10'd25,  1'b1},
      '{OP_DOWN,   8'sd0,    1'b0, 10'd0,   1'b0},
      '{OP_SPARE,  8'sd0,    1'b0, 10'd0,   1'b0},
      '{OP_SAMPLE, 8'sd24,   1'b0, 10'd0,   1'b0},
      '{OP_SAMPLE, 8'sd23,   1'b0, 10'd0,   1'b0},
      '{OP_SAMPLE, 8'sd99,   1'b1, 10'd99,  1'b0},
      '{OP_SAMPLE, 8'sd100,  1'b1, 10'd100, 1'b0},
      '{OP_SAMPLE, 8'sd10,   1'b1, 10'd10,  1'b1},
      '{OP_SAMPLE, 8'sd9,    1'b1, 10'd9,   1'b1},
      '{OP_SAMPLE, -8'sd1,   1'b1, 10'd0,   1'b1},
      '{OP_SAMPLE, 8'sd85,   1'b0, 10'd0,   1'b0},
      '{OP_SAMPLE, -8'sd86,  1'b0, 10'd0,   1'b0},
      '{OP_UP,     8'sd0,    1'b0, 10'd0,   1'b0},
      '{OP_SPARE,  8'sd0,    1'b0, 10'd0,   1'b0}
   };

   hysteresis_thermostat_display_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d digit writes outstanding",
                  cycle_count, pending_digit_writes.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what);
      if (mismatch_count < PRINT_CAP)
         $display("MISMATCH cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Three digit writes for one shown value, saturated to 0..999
   function automatic void queue_display(input int value, input logic relay);
      int      v;
      rsp_type w;
      v = (value < 0) ? 0 : ((value > 999) ? 999 : value);
      w.relay_drive = relay;
      w.last_of_run = 1'b0;
      w.digit_position = POS_HUNDREDS;
      w.digit_value = 4'(v / 100);
      pending_digit_writes.push_back(w);
      w.digit_position = POS_TENS;
      w.digit_value = 4'((v % 100) / 10);
      pending_digit_writes.push_back(w);
      w.digit_position = POS_UNITS;
      w.digit_value = 4'(v % 10);
      w.last_of_run = 1'b1;
      pending_digit_writes.push_back(w);
   endfunction

   // Thermostat update for one accepted item; returns the value to show
   function automatic void advance_thermostat(input req_type item, output int shown);
      int   sp;
      int   temp;
      logic old_relay;
      old_relay = relay_on;
      if (item.op == OP_SAMPLE) begin
         last_sample = $signed(item.temperature);
         shown = last_sample;
      end else begin
         if (item.op == OP_UP) begin
            if (setpoint_now < SP_MAX) setpoint_now = setpoint_now + 8'sd1;
            else top_hits++;
         end else if (item.op == OP_DOWN) begin
            if (setpoint_now > SP_MIN) setpoint_now = setpoint_now - 8'sd1;
            else bottom_hits++;
         end
         shown = setpoint_now;
      end
      sp = setpoint_now;
      temp = last_sample;
      if (temp >= sp) relay_on = 1'b0;
      else if (temp <= sp - int'(hysteresis_cfg)) relay_on = 1'b1;
      if (relay_on != old_relay) relay_flips++;
   endfunction

   // Push one item; push stays high across back-to-back items
   task automatic send_item(input req_type item, input logic typed,
                            input int typed_shown, input logic typed_relay);
      int gap;
      int shown;
      gap = feed_calm ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      advance_thermostat(item, shown);
      if (typed) queue_display(typed_shown, typed_relay);
      else queue_display(shown, relay_on);
      items_sent++;
      if ($urandom_range(0, 19) == 0) feed_calm = !feed_calm;
   endtask

   task automatic press_run(input logic [1:0] op, input int count);
      req_type item;
      item.op = op;
      item.temperature = 8'($urandom);
      repeat (count) send_item(item, 1'b0, 0, 1'b0);
   endtask

   // Mostly samples around the switching band, some presses, some noise
   task automatic send_random_item();
      req_type item;
      int      pick;
      int      h;
      int      t;
      pick = $urandom_range(0, 99);
      h = hysteresis_cfg;
      item.op = OP_SAMPLE;
      item.temperature = 8'($urandom);
      if (pick < 55) begin
         t = setpoint_now;
         t = t + int'($urandom_range(0, 2 * h + 4)) - (h + 2);
         if (t < -128) t = -128;
         if (t > 127) t = 127;
         item.temperature = 8'(t);
      end else if (pick < 70) begin
         t = int'($urandom_range(0, 180)) - 55;
         item.temperature = 8'(t);
      end else if (pick < 80) begin
         item.temperature = 8'($urandom);
      end else if (pick < 95) begin
         press_run($urandom_range(0, 1) ? OP_UP : OP_DOWN, $urandom_range(1, 6));
         return;
      end else begin
         item.op = OP_SPARE;
      end
      send_item(item, 1'b0, 0, 1'b0);
   endtask

   // Drain every expected digit write, then let the core go quiet
   task automatic settle_outputs();
      req_push <= 1'b0;
      while (pending_digit_writes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_hysteresis(input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      hysteresis_cfg = value;
      settings_used++;
   endtask

   // Result side: pops with random stalls and checks each digit write
   initial begin : result_sink
      int      gap;
      rsp_type want;
      rsp_pop <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         gap = sink_calm ? 0 : $urandom_range(0, 14);
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (pending_digit_writes.size() == 0) begin
            flag_mismatch($sformatf("unexpected digit write pos %0d value %0d",
                                    rsp_data.digit_position, rsp_data.digit_value));
         end else begin
            want = pending_digit_writes.pop_front();
            if (rsp_data.digit_position !== want.digit_position)
               flag_mismatch($sformatf("digit_position %0d, expected %0d",
                                       rsp_data.digit_position, want.digit_position));
            if (rsp_data.digit_value !== want.digit_value)
               flag_mismatch($sformatf("digit_value %0d, expected %0d at pos %0d",
                                       rsp_data.digit_value, want.digit_value,
                                       want.digit_position));
            if (rsp_data.relay_drive !== want.relay_drive)
               flag_mismatch($sformatf("relay_drive %b, expected %b",
                                       rsp_data.relay_drive, want.relay_drive));
            if (rsp_data.last_of_run !== want.last_of_run)
               flag_mismatch($sformatf("last_of_run %b, expected %b at pos %0d",
                                       rsp_data.last_of_run, want.last_of_run,
                                       want.digit_position));
            writes_checked++;
         end
         if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
      end
   end

   // Stimulus: reset, directed rows, then phases over several hysteresis settings
   initial begin : stimulus
      req_type    item;
      int         phase;
      int         span;
      logic [3:0] next_hyst;
      reset <= 1'b1;
      req_push <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= '0;
      setpoint_now = SP_RESET;
      last_sample = '0;
      relay_on = 1'b0;
      hysteresis_cfg = HYST_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         item.op = directed_rows[i].op;
         item.temperature = directed_rows[i].temp;
         send_item(item, directed_rows[i].typed, directed_rows[i].shown,
                   directed_rows[i].relay);
      end

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: next_hyst = 4'd0;
            1: next_hyst = 4'd15;
            5: next_hyst = HYST_RESET;
            default: next_hyst = 4'($urandom_range(2, 14));
         endcase
         settle_outputs();
         write_hysteresis(next_hyst);
         // Long press runs carry the setpoint past both range ends
         if (phase == 0) begin
            span = SP_MAX;
            span = span - int'(setpoint_now);
            press_run(OP_UP, span + 4);
         end
         if (phase == 2) begin
            span = setpoint_now;
            span = span - int'(SP_MIN);
            press_run(OP_DOWN, span + 4);
         end
         repeat (25) send_random_item();
      end

      settle_outputs();
      repeat (8) @(posedge clock);
      $display("Sent %0d items, checked %0d digit writes under %0d hysteresis settings",
               items_sent, writes_checked, settings_used);
      $display("Setpoint held at top %0d and bottom %0d times, relay switched %0d times",
               top_hits, bottom_hits, relay_flips);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
